### sv/ddfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddfr_pkg;

  localparam int DIGITS_DEF      = 8;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int STEPS_PER_STAGE = 4;

  localparam logic [7:0] CTRL_BYTE       = 8'h40;
  localparam int         GLYPH_COLS      = 5;
  localparam logic [3:0] BLANK_GLYPH     = 4'd10;
  localparam logic [3:0] GLYPH_LAST      = 4'd10;

  localparam logic [7:0] GLYPH_ROM [11][5] = '{
    '{8'h36, 8'h41, 8'h41, 8'h36, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h36, 8'h00},
    '{8'h30, 8'h49, 8'h49, 8'h06, 8'h00},
    '{8'h00, 8'h49, 8'h49, 8'h36, 8'h00},
    '{8'h06, 8'h08, 8'h08, 8'h36, 8'h00},
    '{8'h06, 8'h49, 8'h49, 8'h30, 8'h00},
    '{8'h36, 8'h49, 8'h49, 8'h30, 8'h00},
    '{8'h00, 8'h01, 8'h01, 8'h36, 8'h00},
    '{8'h36, 8'h49, 8'h49, 8'h36, 8'h00},
    '{8'h06, 8'h49, 8'h49, 8'h36, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic [7:0] glyph_col(input logic [3:0] g, input logic [2:0] c);
    logic [7:0] b;
    b = 8'h00;
    if (g <= GLYPH_LAST && c < 3'(GLYPH_COLS)) begin
      b = GLYPH_ROM[g][c];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

### sv/ddfr_bcd_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module ddfr_bcd_pipe #(
  parameter int DIGITS      = ddfr_pkg::DIGITS_DEF,
  parameter int VALUE_WIDTH = ddfr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic [VALUE_WIDTH-1:0]  in_value,
  output logic                         in_busy,
  output logic                         out_valid,
  output logic [4*DIGITS-1:0]          out_bcd,
  input  wire logic                    out_take
);
  import ddfr_pkg::*;

  localparam int NST   = (VALUE_WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int BCD_W = 4 * DIGITS;
  localparam int ACC_W = BCD_W + VALUE_WIDTH;

  logic                    vld [0:NST];
  logic                    adv [0:NST];
  logic [BCD_W-1:0]        bcd_q [0:NST];
  logic [VALUE_WIDTH-1:0]  bin_q [0:NST];

  assign adv[0]    = !vld[0] || adv[1];
  assign adv[NST]  = !vld[NST] || out_take;
  assign in_busy   = vld[0] && !adv[0];
  assign out_valid = vld[NST];
  assign out_bcd   = bcd_q[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv[0]) begin
      vld[0] <= in_valid;
    end
    if (adv[0] && in_valid) begin
      bcd_q[0] <= '0;
      bin_q[0] <= in_value;
    end
  end

  for (genvar s = 1; s <= NST; s++) begin : g_stage
    logic [ACC_W-1:0] acc;

    if (s < NST) begin : g_adv
      assign adv[s] = !vld[s] || adv[s+1];
    end

    always_comb begin
      acc = {bcd_q[s-1], bin_q[s-1]};
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if ((s - 1) * STEPS_PER_STAGE + k < VALUE_WIDTH) begin
          for (int d = 0; d < DIGITS; d++) begin
            if (acc[VALUE_WIDTH + 4*d +: 4] >= 4'd5) begin
              acc[VALUE_WIDTH + 4*d +: 4] = acc[VALUE_WIDTH + 4*d +: 4] + 4'd3;
            end
          end
          acc = acc << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv[s]) begin
        vld[s] <= vld[s-1];
      end
      if (adv[s] && vld[s-1]) begin
        bcd_q[s] <= acc[ACC_W-1 -: BCD_W];
        bin_q[s] <= acc[VALUE_WIDTH-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### sv/decimal_digit_font_renderer.sv
// Channel  Ports                                          Handshake
// input    start, busy, value                             taken when start && !busy
// output   strobe, data_byte, transfer_start,             one cycle per byte, no stall
//          transfer_end, last
//
// Each number gives DIGITS*6 bytes, one per cycle (48 bytes at 8 digits); the
// byte emitter sets that rate. Conversion runs in ceil(VALUE_WIDTH/4)+1 stages
// ahead of it, and the next number is converted while the current one streams.
// busy rises when the conversion stages are full behind a busy emitter.
// Synchronous reset clears all valid bits and the strobe.
`timescale 1ns / 1ps
`default_nettype none

module decimal_digit_font_renderer #(
  parameter int DIGITS      = ddfr_pkg::DIGITS_DEF,
  parameter int VALUE_WIDTH = ddfr_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        strobe,
  output logic [7:0]                  data_byte,
  output logic                        transfer_start,
  output logic                        transfer_end,
  output logic                        last
);
  import ddfr_pkg::*;

  localparam int BCD_W = 4 * DIGITS;
  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic             pipe_valid;
  logic [BCD_W-1:0] pipe_bcd;
  logic             take;

  ddfr_bcd_pipe #(
    .DIGITS      (DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_value  (value),
    .in_busy   (busy),
    .out_valid (pipe_valid),
    .out_bcd   (pipe_bcd),
    .out_take  (take)
  );

  logic             active;
  logic [BCD_W-1:0] dig_q;
  logic [IDX_W-1:0] idx;
  logic [2:0]       col;
  logic             blank_q;

  logic [3:0] cur_dig;
  logic       final_dig;
  logic       end_col;
  logic       show_blank;
  logic [3:0] glyph_idx;
  logic       done;
  logic [7:0] byte_next;

  always_comb begin
    cur_dig    = dig_q[BCD_W-1 -: 4];
    final_dig  = (idx == IDX_W'(DIGITS - 1));
    end_col    = (col == 3'(GLYPH_COLS));
    show_blank = blank_q && (cur_dig == 4'd0) && !final_dig;
    glyph_idx  = show_blank ? BLANK_GLYPH : cur_dig;
    done       = active && final_dig && end_col;
    take       = !active || done;
    byte_next  = (col == 3'd0) ? CTRL_BYTE : glyph_col(glyph_idx, 3'(col - 3'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (take) begin
        active <= pipe_valid;
      end
    end

    if (active) begin
      data_byte      <= byte_next;
      transfer_start <= (col == 3'd0);
      transfer_end   <= end_col;
      last           <= done;
    end

    if (take) begin
      if (pipe_valid) begin
        dig_q   <= pipe_bcd;
        idx     <= '0;
        col     <= 3'd0;
        blank_q <= 1'b1;
      end
    end else if (end_col) begin
      col     <= 3'd0;
      idx     <= IDX_W'(idx + 1'b1);
      dig_q   <= dig_q << 4;
      blank_q <= blank_q && (cur_dig == 4'd0);
    end else begin
      col <= 3'(col + 3'd1);
    end
  end

endmodule

`default_nettype wire
